>>> hdl/aes128_block_encrypt_defines.svh
// ---------------------------------------------------------------------------
// aes128_block_encrypt_defines
// assertion macros used by the aes128 controller
// ---------------------------------------------------------------------------
`ifndef AES128_BLOCK_ENCRYPT_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define AES128_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aes128 check failed");

// next-cycle implication, checked out of reset
`define AES128_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aes128 check failed");

`endif

>>> hdl/aes128_pkg.sv
// ---------------------------------------------------------------------------
// aes128_pkg
// shared types, codes and the s-box table of the aes-128 block encrypter
// ---------------------------------------------------------------------------
package aes128_pkg;

  // default round count
  localparam int unsigned NumRoundsDef = 10;

  // width of the slot field on the port
  localparam int unsigned SlotW = 4;

  // item opcodes
  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ENCRYPT = 1'b1
  } opcode_e;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic key_we;     // write a round key into the store
    logic load_pt;    // take plaintext and add round key 0
    logic step;       // run one round on the state
    logic final_rnd;  // this round skips mixcolumns and ends the item
  } dp_cmd_t;

  // forward s-box
  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // s-box lookup
  function automatic logic [7:0] sbox(input logic [7:0] a);
    return SBOX[a];
  endfunction

endpackage

>>> hdl/aes128_block_encrypt.sv
// ---------------------------------------------------------------------------
// aes128_block_encrypt
// aes-128 block encryption with round keys loaded from outside
// ---------------------------------------------------------------------------
// A load item (opcode 0) writes one 128-bit round key into slot key_slot of
// the key store and gives no result; slots above NUM_ROUNDS are dropped. An
// encrypt item (opcode 1) is taken in a cycle that adds round key 0, then one
// shared round unit runs one round per cycle while the last round does not
// wait; no new item is taken until the last round is done, and the next item
// is taken in the cycle after it. The ciphertext sits in an output register
// while the next item runs; the last round of that item waits only if the
// earlier ciphertext has still not been taken. Round keys come from a store
// with one write port and one registered read port, slot 0 being read ahead
// while idle. A slot that was never loaded gives an unspecified ciphertext.

module aes128_block_encrypt #(
  parameter int unsigned NUM_ROUNDS = aes128_pkg::NumRoundsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [0:0]                   opcode_i,
  input  logic [aes128_pkg::SlotW-1:0] key_slot_i,
  input  logic [63:0]                  data_lo_i,
  input  logic [63:0]                  data_hi_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [63:0]                  cipher_lo_o,
  output logic [63:0]                  cipher_hi_o
);
  import aes128_pkg::*;

  localparam int unsigned KidxW = $clog2(NUM_ROUNDS + 1);

  dp_cmd_t          cmd;
  logic [KidxW-1:0] rd_addr;

  // sequencing
  aes128_ctrl #(
    .NUM_ROUNDS (NUM_ROUNDS),
    .KIDX_W     (KidxW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .key_slot_i  (key_slot_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr)
  );

  // key store and round unit
  aes128_dp #(
    .NUM_ROUNDS (NUM_ROUNDS),
    .KIDX_W     (KidxW)
  ) u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .rd_addr_i   (rd_addr),
    .wr_addr_i   (key_slot_i[KidxW-1:0]),
    .data_lo_i   (data_lo_i),
    .data_hi_i   (data_hi_i),
    .cipher_lo_o (cipher_lo_o),
    .cipher_hi_o (cipher_hi_o)
  );

endmodule

>>> hdl/aes128_ctrl.sv
// ---------------------------------------------------------------------------
// aes128_ctrl
// controller: input handshake, round sequencing, key read address and
// output valid flag
// ---------------------------------------------------------------------------
`include "aes128_block_encrypt_defines.svh"

module aes128_ctrl #(
  parameter int unsigned NUM_ROUNDS = aes128_pkg::NumRoundsDef,
  parameter int unsigned KIDX_W     = $clog2(NUM_ROUNDS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [0:0]                    opcode_i,
  input  logic [aes128_pkg::SlotW-1:0]  key_slot_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output aes128_pkg::dp_cmd_t           cmd_o,
  output logic [KIDX_W-1:0]             rd_addr_o
);
  import aes128_pkg::*;

  ctrl_state_e       state_q, state_d;
  logic [KIDX_W-1:0] round_q, round_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic              enc_start;
  logic              run;
  logic              last;
  logic              out_free;
  logic              step;
  logic              finish;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
    end
  end

  // handshake decode and round status
  always_comb begin
    run       = (state_q == ST_RUN);
    accept    = in_valid_i && (state_q == ST_IDLE);
    enc_start = accept && (opcode_e'(opcode_i) == OP_ENCRYPT);
    last      = (round_q == KIDX_W'(NUM_ROUNDS));
    out_free  = !out_valid_q || out_ready_i;
    // last round waits for the output register to be free
    step      = run && (!last || out_free);
    finish    = step && last;
  end

  // next state, commands and key read address
  always_comb begin
    state_d       = state_q;
    round_d       = round_q;
    cmd_o.key_we  = accept && (opcode_e'(opcode_i) == OP_LOAD) &&
                    (key_slot_i <= SlotW'(NUM_ROUNDS));
    cmd_o.load_pt = enc_start;
    cmd_o.step    = step;
    cmd_o.final_rnd = last;

    unique case (state_q)
      ST_IDLE: begin
        if (enc_start) begin
          state_d = ST_RUN;
          round_d = KIDX_W'(1);
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_d = ST_IDLE;
        end else if (step) begin
          round_d = KIDX_W'(round_q + 1'b1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // key for the next cycle; slot 0 is kept ready while idle
    priority if (!run || finish) begin
      rd_addr_o = '0;
    end else if (enc_start) begin
      rd_addr_o = KIDX_W'(1);
    end else if (last) begin
      rd_addr_o = round_q;
    end else begin
      rd_addr_o = KIDX_W'(round_q + 1'b1);
    end
    if (enc_start) begin
      rd_addr_o = KIDX_W'(1);
    end
  end

  // output valid flag
  always_comb begin
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // checks
  `AES128_ASSERT_NOW(a_busy_not_ready, clk_i, rst_ni, state_q == ST_RUN, !in_ready_o)
  `AES128_ASSERT_NOW(a_round_range, clk_i, rst_ni, state_q == ST_RUN,
                     (round_q != '0) && (round_q <= KIDX_W'(NUM_ROUNDS)))
  `AES128_ASSERT_NEXT(a_start_round1, clk_i, rst_ni, enc_start,
                      (state_q == ST_RUN) && (round_q == KIDX_W'(1)))
  `AES128_ASSERT_NEXT(a_finish_valid, clk_i, rst_ni, finish,
                      out_valid_q && (state_q == ST_IDLE))

endmodule

>>> hdl/aes128_dp.sv
// ---------------------------------------------------------------------------
// aes128_dp
// datapath: round key store, state register, one shared round unit and
// the ciphertext output register
// ---------------------------------------------------------------------------
module aes128_dp #(
  parameter int unsigned NUM_ROUNDS = aes128_pkg::NumRoundsDef,
  parameter int unsigned KIDX_W     = $clog2(NUM_ROUNDS + 1)
) (
  input  logic                clk_i,
  input  aes128_pkg::dp_cmd_t cmd_i,
  input  logic [KIDX_W-1:0]   rd_addr_i,
  input  logic [KIDX_W-1:0]   wr_addr_i,
  input  logic [63:0]         data_lo_i,
  input  logic [63:0]         data_hi_i,
  output logic [63:0]         cipher_lo_o,
  output logic [63:0]         cipher_hi_o
);
  import aes128_pkg::*;

  localparam int unsigned KeySlots = NUM_ROUNDS + 1;

  logic [127:0] key_mem [KeySlots];
  logic [127:0] key_q;
  logic [127:0] state_q, state_d;
  logic [127:0] cipher_q;
  logic [127:0] data_in;
  logic [127:0] sb_out;
  logic [127:0] mc_out;
  logic [127:0] rnd_out;

  // multiply by x in gf(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // subbytes followed by shiftrows
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(4*c+r) +: 8] = sbox(s[8*(4*((c+r)%4)+r) +: 8]);
      end
    end
    return t;
  endfunction

  // mixcolumns on all four columns
  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      t[32*c +: 8]    = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[32*c+8 +: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[32*c+16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[32*c+24 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return t;
  endfunction

  assign data_in = {data_hi_i, data_lo_i};

  // round key store, registered read with write forwarding
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_we) begin
      key_mem[wr_addr_i] <= data_in;
    end
    if (cmd_i.key_we && (wr_addr_i == rd_addr_i)) begin
      key_q <= data_in;
    end else begin
      key_q <= key_mem[rd_addr_i];
    end
  end

  // shared round unit
  always_comb begin
    sb_out  = sub_shift(state_q);
    mc_out  = mix_columns(sb_out);
    rnd_out = (cmd_i.final_rnd ? sb_out : mc_out) ^ key_q;
  end

  // state update
  always_comb begin
    state_d = state_q;
    if (cmd_i.load_pt) begin
      state_d = data_in ^ key_q;
    end else if (cmd_i.step) begin
      state_d = rnd_out;
    end
  end

  // state and ciphertext registers
  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    if (cmd_i.step && cmd_i.final_rnd) begin
      cipher_q <= rnd_out;
    end
  end

  assign cipher_lo_o = cipher_q[63:0];
  assign cipher_hi_o = cipher_q[127:64];

endmodule

>>> sim/aes128_cipher_checker.sv
// ---------------------------------------------------------------------------
// aes128_cipher_checker
// watches both channels of the aes-128 block encrypter, keeps its own copy
// of the round key store, works out each ciphertext and compares it with
// what the block hands out, oldest first
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes128_cipher_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [0:0]  opcode_i,
  input  logic [3:0]  key_slot_i,
  input  logic [63:0] data_lo_i,
  input  logic [63:0] data_hi_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] cipher_lo_i,
  input  logic [63:0] cipher_hi_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int unsigned Rounds = aes128_pkg::NumRoundsDef;

  // round keys as the block should hold them, plus the substitution table
  logic [63:0]  key_lo [Rounds+1];
  logic [63:0]  key_hi [Rounds+1];
  logic [7:0]   sub_table [256];
  logic [127:0] ciphertext_q [$];
  int           mismatches = 0;
  int           outstanding = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  // doubling in gf(2^8)
  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    int         i;
    acc = 8'h00;
    x   = a;
    y   = b;
    for (i = 0; i < 8; i++) begin
      if (y[0]) acc ^= x;
      x = gf_double(x);
      y = y >> 1;
    end
    return acc;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] b, input int n);
    return (b << n) | (b >> (8 - n));
  endfunction

  // inverse as a^254 (zero stays zero), then the affine map
  function automatic logic [7:0] substitute(input logic [7:0] a);
    logic [7:0] inv;
    logic [7:0] base;
    int         e;
    inv  = 8'h01;
    base = a;
    e    = 254;
    while (e != 0) begin
      if (e & 1) inv = gf_mult(inv, base);
      base = gf_mult(base, base);
      e    = e >> 1;
    end
    return inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
  endfunction

  // full cipher over the stored round keys, result packed as {hi, lo}
  function automatic logic [127:0] encrypt_block(input logic [63:0] pt_lo,
                                                 input logic [63:0] pt_hi);
    logic [7:0]  st [16];
    logic [7:0]  nxt [16];
    logic [7:0]  a0, a1, a2, a3;
    logic [63:0] ct_lo, ct_hi;
    int          i, c, r, rnd;
    for (i = 0; i < 8; i++) begin
      st[i]     = pt_lo[8*i +: 8];
      st[i + 8] = pt_hi[8*i +: 8];
    end
    for (rnd = 0; rnd <= Rounds; rnd++) begin
      // subbytes with shiftrows folded into the index
      if (rnd > 0) begin
        for (c = 0; c < 4; c++)
          for (r = 0; r < 4; r++)
            nxt[4*c + r] = sub_table[st[4*((c + r) & 3) + r]];
        st = nxt;
      end
      // mixcolumns on every round but the first and the last
      if (rnd > 0 && rnd < Rounds) begin
        for (c = 0; c < 4; c++) begin
          a0 = st[4*c];
          a1 = st[4*c + 1];
          a2 = st[4*c + 2];
          a3 = st[4*c + 3];
          st[4*c]     = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
          st[4*c + 1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
          st[4*c + 2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
          st[4*c + 3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
        end
      end
      // add round key
      for (i = 0; i < 8; i++) begin
        st[i]     ^= key_lo[rnd][8*i +: 8];
        st[i + 8] ^= key_hi[rnd][8*i +: 8];
      end
    end
    for (i = 0; i < 8; i++) begin
      ct_lo[8*i +: 8] = st[i];
      ct_hi[8*i +: 8] = st[i + 8];
    end
    return {ct_hi, ct_lo};
  endfunction

  // substitution table and a defined key store
  initial begin
    for (int k = 0; k < 256; k++) sub_table[k] = substitute(8'(k));
    for (int k = 0; k <= Rounds; k++) begin
      key_lo[k] = '0;
      key_hi[k] = '0;
    end
  end

  // results first, since a result never belongs to the item taken on the same edge
  always @(posedge clk_i) begin
    logic [127:0] want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (ciphertext_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t ciphertext with none pending: %h_%h", $realtime,
                     cipher_hi_i, cipher_lo_i);
          mismatches++;
        end else begin
          want = ciphertext_q.pop_front();
          if (cipher_lo_i !== want[63:0] || cipher_hi_i !== want[127:64]) begin
            if (mismatches < 10)
              $display("%0t ciphertext mismatch: expected hi %h lo %h, got hi %h lo %h",
                       $realtime, want[127:64], want[63:0], cipher_hi_i, cipher_lo_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (aes128_pkg::opcode_e'(opcode_i) == aes128_pkg::OP_LOAD) begin
          // slots past the last round are dropped
          if (key_slot_i <= Rounds) begin
            key_lo[key_slot_i] = data_lo_i;
            key_hi[key_slot_i] = data_hi_i;
          end
        end else begin
          ciphertext_q.push_back(encrypt_block(data_lo_i, data_hi_i));
        end
      end
      outstanding <= ciphertext_q.size();
    end
  end

endmodule

>>> sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// drives key loads and plaintext blocks into the aes-128 block encrypter
// with random gaps and output stalls; the checker beside the block predicts
// and compares every ciphertext
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import aes128_pkg::*;

  localparam int unsigned LastSlot = NumRoundsDef;
  localparam int          RandItems = 1800;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  opcode_e     opcode = OP_LOAD;
  logic [3:0]  key_slot = '0;
  logic [63:0] data_lo = '0;
  logic [63:0] data_hi = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] cipher_lo;
  logic [63:0] cipher_hi;
  int          fail_count;
  int          pending;
  bit          steady = 1'b0;

  aes128_block_encrypt dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .opcode_i    (opcode),
    .key_slot_i  (key_slot),
    .data_lo_i   (data_lo),
    .data_hi_i   (data_hi),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .cipher_lo_o (cipher_lo),
    .cipher_hi_o (cipher_hi)
  );

  aes128_cipher_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .opcode_i     (opcode),
    .key_slot_i   (key_slot),
    .data_lo_i    (data_lo),
    .data_hi_i    (data_hi),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .cipher_lo_i  (cipher_lo),
    .cipher_hi_i  (cipher_hi),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #2 clk = ~clk;

  // ciphertext receiver stalls about a third of the time
  always @(posedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 32);
  end

  // 64-bit word, now and then an all-zero or all-one one
  function automatic logic [63:0] data_word();
    int roll;
    roll = $urandom_range(15);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  // present one item after an optional gap and hold it until taken
  task automatic send_item(input opcode_e op, input logic [3:0] slot,
                           input logic [63:0] lo, input logic [63:0] hi);
    while (!steady && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    key_slot <= slot;
    data_lo  <= lo;
    data_hi  <= hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending until every ciphertext is out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int made;
    int roll;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all slots loaded before the first block, zero and all-one keys at the ends
    send_item(OP_LOAD, 4'd0, '0, '0);
    for (int s = 1; s < LastSlot; s++) send_item(OP_LOAD, 4'(s), data_word(), data_word());
    send_item(OP_LOAD, 4'(LastSlot), '1, '1);
    // out-of-range slots must leave the store alone
    send_item(OP_LOAD, 4'd11, '1, '1);
    send_item(OP_LOAD, 4'd15, {$urandom(), $urandom()}, {$urandom(), $urandom()});
    // plaintext extremes, slot field ignored on encrypt
    send_item(OP_ENCRYPT, 4'd15, '0, '0);
    send_item(OP_ENCRYPT, 4'd0, '1, '1);
    send_item(OP_ENCRYPT, 4'd10, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_item(OP_ENCRYPT, 4'd7, {$urandom(), $urandom()}, {$urandom(), $urandom()});
    // key reload straight before a block
    send_item(OP_LOAD, 4'd0, '1, '1);
    send_item(OP_ENCRYPT, 4'd3, '0, '0);
    send_item(OP_LOAD, 4'(LastSlot), '0, '0);
    send_item(OP_ENCRYPT, 4'd12, '1, '0);
    drain_results();

    // random mix of blocks and key reloads, one gap-free stretch
    made = 0;
    while (made < RandItems) begin
      steady = (made >= 1000 && made < 1300);
      if (made % 400 == 200) drain_results();
      roll = $urandom_range(99);
      if (roll < 55) begin
        send_item(OP_ENCRYPT, 4'($urandom_range(15)), data_word(), data_word());
        made++;
      end else if (roll < 93) begin
        send_item(OP_LOAD, 4'($urandom_range(LastSlot)), data_word(), data_word());
        made++;
      end else begin
        send_item(OP_LOAD, 4'($urandom_range(15, LastSlot + 1)), data_word(), data_word());
        made++;
      end
    end
    steady = 1'b0;

    drain_results();
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run time guard
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
